// ===== src/preview_crop_rotate_matrix_assert.svh =====
// Assertion macros shared by the preview crop and rotate matrix block.
// Depends on nothing; included by the top level only.
`ifndef PREVIEW_CROP_ROTATE_MATRIX_ASSERT_SVH
`define PREVIEW_CROP_ROTATE_MATRIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pcr_pkg.sv =====
// Shared types, constants and the sine table generator of the matrix block.
// Depends on nothing; used by pcr_geom, pcr_matrix and the top level.
`default_nettype none

package pcr_pkg;

   localparam logic [8:0] DEG_90  = 9'd90;
   localparam logic [8:0] DEG_180 = 9'd180;
   localparam logic [8:0] DEG_270 = 9'd270;
   localparam logic [8:0] DEG_360 = 9'd360;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic mirror;
      logic scale_x;
   } ctrl_type;

   // Sine of k degrees scaled by 2**frac and rounded to nearest.
   function automatic longint sin_entry(int k, int frac);
      real r;
      r = $sin(real'(k) * 3.14159265358979323846 / 180.0) * (2.0 ** frac);
      return longint'($floor(r + 0.5));
   endfunction

endpackage

`default_nettype wire

// ===== src/pcr_geom.sv =====
// Front end: orientation reduction, size swaps, aspect products, sine lookup
// and divider set-up over three register stages. Uses pcr_pkg.
`default_nettype none

module pcr_geom #(
   parameter int FRAC_BITS = 16,
   parameter int DIM_BITS  = 13
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         adv,
   input  wire                         in_valid,
   input  wire  [DIM_BITS-1:0]         view_w,
   input  wire  [DIM_BITS-1:0]         view_h,
   input  wire  [DIM_BITS-1:0]         video_w,
   input  wire  [DIM_BITS-1:0]         video_h,
   input  wire  [8:0]                  orientation_deg,
   input  wire                         front_camera,
   input  wire                         api_two,
   input  wire                         normal_mode,
   output logic                        out_valid,
   output logic [2*DIM_BITS-1:0]       out_rem,
   output logic [FRAC_BITS:0]          out_low,
   output logic [2*DIM_BITS-1:0]       out_den,
   output logic signed [FRAC_BITS+1:0] out_s,
   output logic signed [FRAC_BITS+1:0] out_c,
   output pcr_pkg::ctrl_type           out_ctrl
);

   localparam int PW = 2 * DIM_BITS;
   localparam int NW = PW + FRAC_BITS + 1;

   logic [FRAC_BITS:0] sin_tab [0:90];

   for (genvar g = 0; g <= 90; g++) begin : g_tab
      localparam longint VAL = pcr_pkg::sin_entry(g, FRAC_BITS);
      assign sin_tab[g] = VAL[FRAC_BITS:0];
   end

   // Stage one.
   logic                v1_ff, v1_in;
   logic [DIM_BITS-1:0] lw1_ff, lh1_ff, vw1_ff, vh1_ff;
   logic [DIM_BITS-1:0] lw1_in, lh1_in, vw1_in, vh1_in;
   logic [1:0]          quad1_ff, quad1_in;
   logic [6:0]          k1_ff, k1_in;
   logic                mir1_ff, mir1_in;

   logic [8:0]          orient, rot, kfull;
   logic [DIM_BITS-1:0] dvw, dvh, dlw, dlh;

   always_comb begin
      orient = (orientation_deg >= pcr_pkg::DEG_360) ?
               orientation_deg - pcr_pkg::DEG_360 : orientation_deg;
      rot = (orient < pcr_pkg::DEG_90) ? orient + pcr_pkg::DEG_270 : orient - pcr_pkg::DEG_90;
      dvw = (view_w == '0) ? DIM_BITS'(1) : view_w;
      dvh = (view_h == '0) ? DIM_BITS'(1) : view_h;
      dlw = (video_w == '0) ? DIM_BITS'(1) : video_w;
      dlh = (video_h == '0) ? DIM_BITS'(1) : video_h;
      if (rot == pcr_pkg::DEG_90 || rot == pcr_pkg::DEG_270) begin
         lw1_in = dlh;
         lh1_in = dlw;
      end else begin
         lw1_in = dlw;
         lh1_in = dlh;
      end
      if (normal_mode && (orient == pcr_pkg::DEG_90 || orient == pcr_pkg::DEG_270)) begin
         vw1_in = dvh;
         vh1_in = dvw;
      end else begin
         vw1_in = dvw;
         vh1_in = dvh;
      end
      if (rot < pcr_pkg::DEG_90) begin
         quad1_in = pcr_pkg::QUAD_0;
         kfull    = rot;
      end else if (rot < pcr_pkg::DEG_180) begin
         quad1_in = pcr_pkg::QUAD_1;
         kfull    = rot - pcr_pkg::DEG_90;
      end else if (rot < pcr_pkg::DEG_270) begin
         quad1_in = pcr_pkg::QUAD_2;
         kfull    = rot - pcr_pkg::DEG_180;
      end else begin
         quad1_in = pcr_pkg::QUAD_3;
         kfull    = rot - pcr_pkg::DEG_270;
      end
      k1_in   = kfull[6:0];
      mir1_in = api_two && front_camera;
      v1_in   = in_valid;
   end

   // Stage two.
   logic                        v2_ff, v2_in;
   logic [PW-1:0]               p2_ff, q2_ff, p2_in, q2_in;
   logic signed [FRAC_BITS+1:0] s2_ff, c2_ff, s2_in, c2_in;
   logic                        mir2_ff;
   logic signed [FRAC_BITS+1:0] sk, ck;
   logic [6:0]                  kc;

   always_comb begin
      v2_in = v1_ff;
      p2_in = PW'(lw1_ff) * PW'(vh1_ff);
      q2_in = PW'(vw1_ff) * PW'(lh1_ff);
      kc    = 7'd90 - k1_ff;
      sk    = $signed({1'b0, sin_tab[k1_ff]});
      ck    = $signed({1'b0, sin_tab[kc]});
      case (quad1_ff)
         pcr_pkg::QUAD_0: begin
            s2_in = sk;
            c2_in = ck;
         end
         pcr_pkg::QUAD_1: begin
            s2_in = ck;
            c2_in = -sk;
         end
         pcr_pkg::QUAD_2: begin
            s2_in = -sk;
            c2_in = -ck;
         end
         default: begin
            s2_in = -ck;
            c2_in = sk;
         end
      endcase
   end

   // Stage three: the smaller product over the larger one.
   logic                        v3_in;
   logic [PW-1:0]               num, den3_in;
   logic [NW-1:0]               dividend;
   pcr_pkg::ctrl_type           ctrl3_in;

   always_comb begin
      v3_in            = v2_ff;
      ctrl3_in.mirror  = mir2_ff;
      ctrl3_in.scale_x = p2_ff > q2_ff;
      num      = ctrl3_in.scale_x ? q2_ff : p2_ff;
      den3_in  = ctrl3_in.scale_x ? p2_ff : q2_ff;
      dividend = {1'b0, num, {FRAC_BITS{1'b0}}} + NW'(den3_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         out_valid <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lw1_ff   <= lw1_in;
         lh1_ff   <= lh1_in;
         vw1_ff   <= vw1_in;
         vh1_ff   <= vh1_in;
         quad1_ff <= quad1_in;
         k1_ff    <= k1_in;
         mir1_ff  <= mir1_in;
         p2_ff    <= p2_in;
         q2_ff    <= q2_in;
         s2_ff    <= s2_in;
         c2_ff    <= c2_in;
         mir2_ff  <= mir1_ff;
         out_rem  <= dividend[NW-1:FRAC_BITS+1];
         out_low  <= dividend[FRAC_BITS:0];
         out_den  <= den3_in;
         out_s    <= s2_ff;
         out_c    <= c2_ff;
         out_ctrl <= ctrl3_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pcr_div_stage.sv =====
// One restoring division stage that settles one quotient bit per register.
// Depends on nothing; chained by the top level.
`default_nettype none

module pcr_div_stage #(
   parameter int DW  = 26,
   parameter int QW  = 17,
   parameter int BIT = 0,
   parameter int SW  = 38
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           adv,
   input  wire           in_valid,
   input  wire  [DW-1:0] in_rem,
   input  wire  [QW-1:0] in_low,
   input  wire  [DW-1:0] in_den,
   input  wire  [QW-1:0] in_quo,
   input  wire  [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_rem,
   output logic [QW-1:0] out_low,
   output logic [DW-1:0] out_den,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [DW:0]   trial, diff;
   logic          fits;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] quo_in;

   always_comb begin
      trial  = {in_rem, in_low[BIT]};
      diff   = trial - {1'b0, in_den};
      fits   = trial >= {1'b0, in_den};
      rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_in = in_quo;
      quo_in[BIT] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_rem  <= rem_in;
         out_low  <= in_low;
         out_den  <= in_den;
         out_quo  <= quo_in;
         out_side <= in_side;
      end
   end

endmodule

`default_nettype wire

// ===== src/pcr_matrix.sv =====
// Back end: scaled rotation products, rounding and translation terms over
// three register stages. Uses pcr_pkg.
`default_nettype none

module pcr_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         adv,
   input  wire                         in_valid,
   input  wire  [FRAC_BITS:0]          in_quo,
   input  wire  signed [FRAC_BITS+1:0] in_s,
   input  wire  signed [FRAC_BITS+1:0] in_c,
   input  pcr_pkg::ctrl_type           in_ctrl,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+2:0] a00,
   output logic signed [FRAC_BITS+2:0] a10,
   output logic signed [FRAC_BITS+2:0] a01,
   output logic signed [FRAC_BITS+2:0] a11,
   output logic signed [FRAC_BITS+2:0] shift_x,
   output logic signed [FRAC_BITS+2:0] shift_y
);

   localparam int LW = FRAC_BITS + 2;
   localparam int PW = 2 * LW;
   localparam logic signed [LW-1:0]   ONE  = LW'(1) << FRAC_BITS;
   localparam logic signed [PW-1:0]   HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [LW+1:0]   ONE_W = (LW + 2)'(1) << FRAC_BITS;

   logic signed [LW-1:0] quo, sx, sy, ex, ns;
   logic                 v1_ff, v2_ff;
   logic signed [PW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [PW-1:0] p00_in, p01_in, p10_in, p11_in;
   logic signed [PW-1:0] r00, r01, r10, r11;
   logic signed [LW-1:0] l00_ff, l01_ff, l10_ff, l11_ff;
   logic signed [LW+1:0] tx, ty;

   always_comb begin
      quo    = $signed({1'b0, in_quo});
      sx     = in_ctrl.scale_x ? quo : ONE;
      sy     = in_ctrl.scale_x ? ONE : quo;
      ex     = in_ctrl.mirror ? -sx : sx;
      ns     = -in_s;
      p00_in = PW'(in_c) * PW'(ex);
      p01_in = PW'(ns) * PW'(sy);
      p10_in = PW'(in_s) * PW'(ex);
      p11_in = PW'(in_c) * PW'(sy);
      r00    = (p00_ff + HALF) >>> FRAC_BITS;
      r01    = (p01_ff + HALF) >>> FRAC_BITS;
      r10    = (p10_ff + HALF) >>> FRAC_BITS;
      r11    = (p11_ff + HALF) >>> FRAC_BITS;
      tx     = (ONE_W - (LW + 2)'(l00_ff) - (LW + 2)'(l01_ff) + (LW + 2)'(1)) >>> 1;
      ty     = (ONE_W - (LW + 2)'(l10_ff) - (LW + 2)'(l11_ff) + (LW + 2)'(1)) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         out_valid <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         l00_ff  <= r00[LW-1:0];
         l01_ff  <= r01[LW-1:0];
         l10_ff  <= r10[LW-1:0];
         l11_ff  <= r11[LW-1:0];
         a00     <= (LW + 1)'(l00_ff);
         a01     <= (LW + 1)'(l01_ff);
         a10     <= (LW + 1)'(l10_ff);
         a11     <= (LW + 1)'(l11_ff);
         shift_x <= tx[LW:0];
         shift_y <= ty[LW:0];
      end
   end

endmodule

`default_nettype wire

// ===== src/preview_crop_rotate_matrix.sv =====
// Preview crop and rotate texture matrix block: one geometry request per
// item on req_, six matrix entries in signed Q3.FRAC_BITS per item on rsp_.
// An item is taken when req_valid is high and req_stall is low, and a
// result is taken when rsp_valid is high and rsp_stall is low.
// The block is one pipeline that advances as a whole: three front stages
// reduce the orientation, swap sizes, form the aspect products and look up
// sine and cosine; FRAC_BITS+1 divider stages settle one scale bit each;
// three back stages multiply, round and form the translation entries.
// A new item is taken in every cycle in which the receiver does not stall,
// so the sustained rate is one item per cycle while rsp_stall stays low.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; no other state is reset and there is
// no clearing pass, so items are taken from the first cycle after reset.
// Sizes of zero are treated as one, and orientations of 360 and above are
// reduced by 360.
`default_nettype none

`include "preview_crop_rotate_matrix_assert.svh"

module preview_crop_rotate_matrix #(
   parameter int FRAC_BITS = 16,
   parameter int DIM_BITS  = 13
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [DIM_BITS-1:0]         req_view_w,
   input  wire  [DIM_BITS-1:0]         req_view_h,
   input  wire  [DIM_BITS-1:0]         req_video_w,
   input  wire  [DIM_BITS-1:0]         req_video_h,
   input  wire  [8:0]                  req_orientation_deg,
   input  wire                         req_front_camera,
   input  wire                         req_api_two,
   input  wire                         req_normal_mode,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic signed [FRAC_BITS+2:0] rsp_a00,
   output logic signed [FRAC_BITS+2:0] rsp_a10,
   output logic signed [FRAC_BITS+2:0] rsp_a01,
   output logic signed [FRAC_BITS+2:0] rsp_a11,
   output logic signed [FRAC_BITS+2:0] rsp_shift_x,
   output logic signed [FRAC_BITS+2:0] rsp_shift_y
);

   localparam int DW = 2 * DIM_BITS;
   localparam int QW = FRAC_BITS + 1;
   localparam int LW = FRAC_BITS + 2;
   localparam int SW = 2 * LW + $bits(pcr_pkg::ctrl_type);
   localparam int NS = FRAC_BITS + 1;
   localparam logic [QW-1:0] QUO_MAX = QW'(1) << FRAC_BITS;
   localparam logic signed [FRAC_BITS+2:0] OUT_ONE = (FRAC_BITS + 3)'(1) << FRAC_BITS;

   logic adv;

   logic                 dv  [0:NS];
   logic [DW-1:0]        drem [0:NS];
   logic [QW-1:0]        dlow [0:NS];
   logic [DW-1:0]        dden [0:NS];
   logic [QW-1:0]        dquo [0:NS];
   logic [SW-1:0]        dside [0:NS];

   logic signed [LW-1:0] g_s, g_c;
   pcr_pkg::ctrl_type    g_ctrl, m_ctrl;
   logic signed [LW-1:0] m_s, m_c;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   pcr_geom #(
      .FRAC_BITS(FRAC_BITS),
      .DIM_BITS (DIM_BITS)
   ) u_geom (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_valid),
      .view_w         (req_view_w),
      .view_h         (req_view_h),
      .video_w        (req_video_w),
      .video_h        (req_video_h),
      .orientation_deg(req_orientation_deg),
      .front_camera   (req_front_camera),
      .api_two        (req_api_two),
      .normal_mode    (req_normal_mode),
      .out_valid      (dv[0]),
      .out_rem        (drem[0]),
      .out_low        (dlow[0]),
      .out_den        (dden[0]),
      .out_s          (g_s),
      .out_c          (g_c),
      .out_ctrl       (g_ctrl)
   );

   assign dquo[0]  = '0;
   assign dside[0] = {g_s, g_c, g_ctrl};

   for (genvar j = 0; j < NS; j++) begin : g_div
      pcr_div_stage #(
         .DW (DW),
         .QW (QW),
         .BIT(FRAC_BITS - j),
         .SW (SW)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (dv[j]),
         .in_rem   (drem[j]),
         .in_low   (dlow[j]),
         .in_den   (dden[j]),
         .in_quo   (dquo[j]),
         .in_side  (dside[j]),
         .out_valid(dv[j+1]),
         .out_rem  (drem[j+1]),
         .out_low  (dlow[j+1]),
         .out_den  (dden[j+1]),
         .out_quo  (dquo[j+1]),
         .out_side (dside[j+1])
      );
   end

   assign {m_s, m_c, m_ctrl} = dside[NS];

   pcr_matrix #(
      .FRAC_BITS(FRAC_BITS)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (dv[NS]),
      .in_quo   (dquo[NS]),
      .in_s     (m_s),
      .in_c     (m_c),
      .in_ctrl  (m_ctrl),
      .out_valid(rsp_valid),
      .a00      (rsp_a00),
      .a10      (rsp_a10),
      .a01      (rsp_a01),
      .a11      (rsp_a11),
      .shift_x  (rsp_shift_x),
      .shift_y  (rsp_shift_y)
   );

   `PCR_ASSERT_SAME(a_scale_max, clock, reset, dv[NS], dquo[NS] <= QUO_MAX, "scale above one")
   `PCR_ASSERT_SAME(a_rem_below_den, clock, reset, dv[0], drem[0] < dden[0], "divider start out of range")
   `PCR_ASSERT_SAME(a_a00_range, clock, reset, rsp_valid, rsp_a00 <= OUT_ONE && rsp_a00 >= -OUT_ONE, "a00 magnitude above one")
   `PCR_ASSERT_NEXT(a_hold_on_stall, clock, reset, req_stall, $stable(dquo[NS]) && rsp_valid, "pipeline moved while stalled")

endmodule

`default_nettype wire
